FILE: src/achr_pkg.sv
// Shared types, codes and helpers for the AVI chunk header resync scanner.
package achr_pkg;

   localparam int STREAM_SLOTS_DEFAULT = 16;

   localparam int OFFSET_W = 40;
   localparam int SIZE_W   = 32;
   localparam int NUM_W    = 7;
   localparam int SUFFIX_W = 16;
   localparam int HITS_W   = 3;
   localparam int COUNT_W  = 5;

   localparam logic [1:0] OP_RESTART = 2'd0;
   localparam logic [1:0] OP_BYTE    = 2'd1;
   localparam logic [1:0] OP_END     = 2'd2;

   localparam logic [1:0] KIND_MEDIA   = 2'd0;
   localparam logic [1:0] KIND_SKIP    = 2'd1;
   localparam logic [1:0] KIND_PALETTE = 2'd2;
   localparam logic [1:0] KIND_END     = 2'd3;

   localparam logic CSR_DATA_END     = 1'b0;
   localparam logic CSR_STREAM_COUNT = 1'b1;

   localparam logic [HITS_W-1:0]   HITS_LIMIT   = 3'd5;
   localparam logic [OFFSET_W:0]   EARLY_WINDOW = 41'd9;
   localparam logic [NUM_W-1:0]    NO_STREAM    = 7'd100;

   localparam logic [7:0] CH_0 = 8'h30;
   localparam logic [7:0] CH_9 = 8'h39;
   localparam logic [7:0] CH_I = 8'h69;
   localparam logic [7:0] CH_X = 8'h78;
   localparam logic [7:0] CH_J = 8'h4A;
   localparam logic [7:0] CH_U = 8'h55;
   localparam logic [7:0] CH_N = 8'h4E;
   localparam logic [7:0] CH_K = 8'h4B;
   localparam logic [7:0] CH_P = 8'h70;
   localparam logic [7:0] CH_C = 8'h63;

   typedef logic [7:0][7:0] window_type;

   typedef struct packed {
      logic [1:0]          op;
      logic [7:0]          data_byte;
      logic [OFFSET_W-1:0] start_offset;
   } req_word_type;

   typedef struct packed {
      logic [1:0]          kind;
      logic [NUM_W-1:0]    stream_number;
      logic [SIZE_W-1:0]   chunk_size;
      logic [OFFSET_W-1:0] header_end_offset;
      logic [SUFFIX_W-1:0] tag_suffix;
   } rsp_word_type;

   typedef struct packed {
      logic [HITS_W-1:0]   hits;
      logic [SUFFIX_W-1:0] suffix;
   } entry_type;

   typedef struct packed {
      window_type          window;
      logic [3:0]          fill;
      logic [OFFSET_W:0]   early_limit;
      logic [OFFSET_W-1:0] cur;
      logic                scanning;
   } scan_state_type;

   typedef struct packed {
      logic             res_valid;
      logic             wr_en;
      entry_type        wr_entry;
      logic [NUM_W-1:0] media_num;
   } step_type;

   function automatic logic [NUM_W-1:0] two_digits(input logic [7:0] a, input logic [7:0] b);
      logic da;
      logic db;
      da = (a >= CH_0) && (a <= CH_9);
      db = (b >= CH_0) && (b <= CH_9);
      if (da && db) begin
         two_digits = NUM_W'({a[3:0], 3'b000}) + NUM_W'({a[3:0], 1'b0}) + NUM_W'(b[3:0]);
      end else begin
         two_digits = NO_STREAM;
      end
   endfunction

endpackage

FILE: src/achr_if.sv
// Valid/ready channel interfaces for request and response words.
interface achr_req_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     op;
   logic [7:0]                     data_byte;
   logic [achr_pkg::OFFSET_W-1:0]  start_offset;

   modport source (output valid, output op, output data_byte, output start_offset,
                   input ready);
   modport sink (input valid, input op, input data_byte, input start_offset,
                 output ready);
endinterface

interface achr_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     kind;
   logic [achr_pkg::NUM_W-1:0]     stream_number;
   logic [achr_pkg::SIZE_W-1:0]    chunk_size;
   logic [achr_pkg::OFFSET_W-1:0]  header_end_offset;
   logic [achr_pkg::SUFFIX_W-1:0]  tag_suffix;

   modport source (output valid, output kind, output stream_number, output chunk_size,
                   output header_end_offset, output tag_suffix, input ready);
   modport sink (input valid, input kind, input stream_number, input chunk_size,
                 input header_end_offset, input tag_suffix, output ready);
endinterface

FILE: src/achr_stream_table.sv
// Per-stream suffix and hit count memory with registered read and write bypass.
module achr_stream_table #(
   parameter int STREAM_SLOTS = achr_pkg::STREAM_SLOTS_DEFAULT,
   parameter int IDX_W = (STREAM_SLOTS > 1) ? $clog2(STREAM_SLOTS) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [IDX_W-1:0]    rd_addr,
   output achr_pkg::entry_type rd_data,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_addr,
   input  achr_pkg::entry_type wr_data
);

   achr_pkg::entry_type mem [STREAM_SLOTS];
   logic [STREAM_SLOTS-1:0] valid_ff;
   achr_pkg::entry_type mem_rd_ff;
   achr_pkg::entry_type byp_data_ff;
   logic rd_valid_ff;
   logic byp_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      mem_rd_ff   <= mem[rd_addr];
      byp_data_ff <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
         byp_ff      <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
         byp_ff      <= wr_en && (wr_addr == rd_addr);
      end
   end

   assign rd_data = byp_ff ? byp_data_ff : (rd_valid_ff ? mem_rd_ff : '0);

endmodule

FILE: src/achr_header_match.sv
// Next-state and result logic: window shift, header tests and stream table update.
module achr_header_match (
   input  achr_pkg::req_word_type          item,
   input  achr_pkg::scan_state_type        st,
   input  logic [achr_pkg::OFFSET_W-1:0]   data_end,
   input  logic [achr_pkg::NUM_W-1:0]      count,
   input  achr_pkg::entry_type             entry,
   output achr_pkg::scan_state_type        nxt,
   output achr_pkg::rsp_word_type          res,
   output achr_pkg::step_type              step
);

   achr_pkg::window_type             d;
   logic [achr_pkg::SIZE_W-1:0]      size;
   logic [achr_pkg::SUFFIX_W-1:0]    suffix;
   logic [achr_pkg::OFFSET_W:0]      reach;
   logic [achr_pkg::NUM_W-1:0]       n_ix;
   logic [achr_pkg::NUM_W-1:0]       n_media;
   logic                             same;
   logic                             loose;

   assign d       = {item.data_byte, st.window[7:1]};
   assign size    = {d[7], d[6], d[5], d[4]};
   assign suffix  = {d[2], d[3]};
   assign reach   = {1'b0, st.cur} + achr_pkg::OFFSET_W'(0) + (achr_pkg::OFFSET_W+1)'(size);
   assign n_ix    = achr_pkg::two_digits(d[2], d[3]);
   assign n_media = achr_pkg::two_digits(d[0], d[1]);
   assign same    = entry.suffix == suffix;
   assign loose   = ((entry.hits < achr_pkg::HITS_LIMIT) || (st.early_limit > {1'b0, st.cur}))
                    && !d[2][7] && !d[3][7];

   always_comb begin
      nxt = st;
      res = '0;
      step.res_valid = 1'b0;
      step.wr_en = 1'b0;
      step.media_num = n_media;
      if (same) begin
         step.wr_entry.suffix = entry.suffix;
         step.wr_entry.hits = (entry.hits < achr_pkg::HITS_LIMIT) ?
                              entry.hits + achr_pkg::HITS_W'(1) : entry.hits;
      end else begin
         step.wr_entry.suffix = suffix;
         step.wr_entry.hits = '0;
      end
      res.header_end_offset = st.cur;
      res.chunk_size = size;
      res.tag_suffix = suffix;

      case (item.op)
         achr_pkg::OP_RESTART: begin
            nxt.window = '0;
            nxt.fill = '0;
            nxt.cur = item.start_offset;
            nxt.early_limit = {1'b0, item.start_offset} + achr_pkg::EARLY_WINDOW;
            nxt.scanning = 1'b1;
         end
         achr_pkg::OP_BYTE: begin
            if (st.scanning) begin
               if (st.cur >= data_end) begin
                  nxt.scanning = 1'b0;
                  step.res_valid = 1'b1;
                  res = '0;
                  res.kind = achr_pkg::KIND_END;
                  res.header_end_offset = st.cur;
               end else begin
                  nxt.window = d;
                  nxt.fill = (st.fill < 4'd8) ? st.fill + 4'd1 : st.fill;
                  nxt.cur = st.cur + achr_pkg::OFFSET_W'(1);
                  if ((st.fill >= 4'd7) && !(reach > {1'b0, data_end})) begin
                     if ((d[0] == achr_pkg::CH_I) && (d[1] == achr_pkg::CH_X) && (n_ix < count)) begin
                        nxt.scanning = 1'b0;
                        step.res_valid = 1'b1;
                        res.kind = achr_pkg::KIND_SKIP;
                        res.stream_number = n_ix;
                     end else if ((d[0] == achr_pkg::CH_J) && (d[1] == achr_pkg::CH_U) &&
                                  (d[2] == achr_pkg::CH_N) && (d[3] == achr_pkg::CH_K)) begin
                        nxt.scanning = 1'b0;
                        step.res_valid = 1'b1;
                        res.kind = achr_pkg::KIND_SKIP;
                        res.stream_number = '0;
                     end else if (n_media < count) begin
                        if (loose || same) begin
                           nxt.scanning = 1'b0;
                           step.res_valid = 1'b1;
                           step.wr_en = 1'b1;
                           res.kind = achr_pkg::KIND_MEDIA;
                           res.stream_number = n_media;
                        end else if ((d[2] == achr_pkg::CH_P) && (d[3] == achr_pkg::CH_C)) begin
                           nxt.scanning = 1'b0;
                           step.res_valid = 1'b1;
                           res.kind = achr_pkg::KIND_PALETTE;
                           res.stream_number = n_media;
                        end
                     end
                  end
               end
            end
         end
         achr_pkg::OP_END: begin
            if (st.scanning) begin
               nxt.scanning = 1'b0;
               step.res_valid = 1'b1;
               res = '0;
               res.kind = achr_pkg::KIND_END;
               res.header_end_offset = st.cur;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

FILE: src/avi_chunk_header_resync.sv
// Top level of the AVI chunk header resync scanner.
// The scanner takes one file byte per word and one word per clock. A word is held in
// the input register, is checked against the shifted 8-byte window in a single pass and its
// result, if any, shows on the response channel on the next cycle. A word that makes a result
// while the previous result is still unaccepted waits in the input register until that one
// leaves; words that make no result keep flowing. The per-stream suffix table is a memory whose
// read is issued one word ahead from the next window's two stream digits, with a bypass
// for a write to the same stream in that cycle. The table needs no clearing pass: each
// entry has a valid bit that reset clears.
module avi_chunk_header_resync #(
   parameter int STREAM_SLOTS = achr_pkg::STREAM_SLOTS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   achr_req_if.sink                      req_chan,
   achr_rsp_if.source                    rsp_chan,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [achr_pkg::OFFSET_W-1:0] csr_data
);

   localparam int IDX_W = (STREAM_SLOTS > 1) ? $clog2(STREAM_SLOTS) : 1;

   logic [achr_pkg::OFFSET_W-1:0] data_end_ff;
   logic [achr_pkg::COUNT_W-1:0]  stream_count_ff;
   logic [achr_pkg::NUM_W-1:0]    count;

   logic                          in_valid_ff;
   achr_pkg::req_word_type        in_ff;
   achr_pkg::scan_state_type      st_ff;
   achr_pkg::scan_state_type      st_nxt;
   achr_pkg::scan_state_type      st_in;
   logic                          rsp_valid_ff;
   achr_pkg::rsp_word_type        rsp_ff;
   achr_pkg::rsp_word_type        res;
   achr_pkg::step_type            step;
   achr_pkg::entry_type           entry;
   logic                          advance;
   logic [achr_pkg::NUM_W-1:0]    ahead_num;
   logic [IDX_W-1:0]              rd_addr;

   assign count = ({2'b00, stream_count_ff} > achr_pkg::NUM_W'(STREAM_SLOTS)) ?
                  achr_pkg::NUM_W'(STREAM_SLOTS) : {2'b00, stream_count_ff};

   achr_header_match u_match (
      .item     (in_ff),
      .st       (st_ff),
      .data_end (data_end_ff),
      .count    (count),
      .entry    (entry),
      .nxt      (st_nxt),
      .res      (res),
      .step     (step)
   );

   assign advance = in_valid_ff && (!step.res_valid || !rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign st_in = advance ? st_nxt : st_ff;

   assign ahead_num = achr_pkg::two_digits(st_in.window[1], st_in.window[2]);
   assign rd_addr = (ahead_num < achr_pkg::NUM_W'(STREAM_SLOTS)) ? IDX_W'(ahead_num) : '0;

   achr_stream_table #(
      .STREAM_SLOTS (STREAM_SLOTS),
      .IDX_W        (IDX_W)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .rd_data (entry),
      .wr_en   (advance && step.wr_en),
      .wr_addr (IDX_W'(step.media_num)),
      .wr_data (step.wr_entry)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         data_end_ff     <= '0;
         stream_count_ff <= '0;
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         st_ff           <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               achr_pkg::CSR_DATA_END:     data_end_ff <= csr_data;
               achr_pkg::CSR_STREAM_COUNT: stream_count_ff <= csr_data[achr_pkg::COUNT_W-1:0];
               default: begin
               end
            endcase
         end
         if (req_chan.valid && req_chan.ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance && step.res_valid) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         st_ff <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_ff.op           <= req_chan.op;
         in_ff.data_byte    <= req_chan.data_byte;
         in_ff.start_offset <= req_chan.start_offset;
      end
      if (advance && step.res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.kind              = rsp_ff.kind;
   assign rsp_chan.stream_number     = rsp_ff.stream_number;
   assign rsp_chan.chunk_size        = rsp_ff.chunk_size;
   assign rsp_chan.header_end_offset = rsp_ff.header_end_offset;
   assign rsp_chan.tag_suffix        = rsp_ff.tag_suffix;

endmodule

FILE: sim/achr_scan_checker.sv
// Scoreboard for the chunk header scanner: mirrors registers, predicts chunk words, compares.
module achr_scan_checker
   import achr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   achr_req_if                 req_chan,
   achr_rsp_if                 rsp_chan,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [OFFSET_W-1:0] csr_data,
   output int                  failures,
   output int                  outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STREAMS = STREAM_SLOTS_DEFAULT;

   logic [OFFSET_W-1:0] end_offset;
   logic [COUNT_W-1:0]  stream_limit;

   logic [7:0]          win [8];
   int unsigned         fill;
   logic [OFFSET_W-1:0] scan_origin;
   logic [OFFSET_W-1:0] next_offset;
   logic                scan_active;
   logic [SUFFIX_W-1:0] last_suffix [STREAMS];
   int unsigned         suffix_run [STREAMS];

   rsp_word_type        pending_chunks [$];
   rsp_word_type        want;

   function automatic int tag_stream(input logic [7:0] hi, input logic [7:0] lo);
      if (hi >= CH_0 && hi <= CH_9 && lo >= CH_0 && lo <= CH_9)
         return (hi - CH_0) * 10 + (lo - CH_0);
      return NO_STREAM;
   endfunction

   task automatic find_header(input logic [1:0] op, input logic [7:0] b,
                              input logic [OFFSET_W-1:0] start);
      rsp_word_type        hit;
      logic [OFFSET_W-1:0] last;
      logic [SIZE_W-1:0]   size;
      logic [SUFFIX_W-1:0] sfx;
      int                  n;
      int                  streams;
      bit                  same;
      bit                  loose;
      bit                  found;
      found = 1'b0;
      hit = '0;
      streams = (stream_limit > STREAMS) ? STREAMS : int'(stream_limit);
      if (op == OP_RESTART) begin
         scan_origin = start;
         next_offset = start;
         for (int k = 0; k < 8; k++) win[k] = '0;
         fill = 0;
         scan_active = 1'b1;
      end else if ((op == OP_BYTE || op == OP_END) && scan_active) begin
         if (op == OP_END || next_offset >= end_offset) begin
            found = 1'b1;
            hit.kind = KIND_END;
            hit.header_end_offset = next_offset;
         end else begin
            last = next_offset;
            for (int k = 0; k < 7; k++) win[k] = win[k+1];
            win[7] = b;
            if (fill < 8) fill++;
            next_offset = next_offset + 1'b1;
            size = {win[7], win[6], win[5], win[4]};
            sfx = {win[2], win[3]};
            if (fill == 8 && {2'b00, last} + size <= {2'b00, end_offset}) begin
               hit.chunk_size = size;
               hit.header_end_offset = last;
               hit.tag_suffix = sfx;
               n = tag_stream(win[2], win[3]);
               if (win[0] == CH_I && win[1] == CH_X && n < streams) begin
                  found = 1'b1;
                  hit.kind = KIND_SKIP;
                  hit.stream_number = NUM_W'(n);
               end else if (win[0] == CH_J && win[1] == CH_U && win[2] == CH_N &&
                            win[3] == CH_K) begin
                  found = 1'b1;
                  hit.kind = KIND_SKIP;
               end else begin
                  n = tag_stream(win[0], win[1]);
                  if (n < streams) begin
                     same = (last_suffix[n] == sfx);
                     loose = (suffix_run[n] < HITS_LIMIT ||
                              {1'b0, scan_origin} + EARLY_WINDOW > {1'b0, last}) &&
                             !win[2][7] && !win[3][7];
                     if (loose || same) begin
                        if (same) begin
                           if (suffix_run[n] < HITS_LIMIT) suffix_run[n]++;
                        end else begin
                           last_suffix[n] = sfx;
                           suffix_run[n] = 0;
                        end
                        found = 1'b1;
                        hit.kind = KIND_MEDIA;
                        hit.stream_number = NUM_W'(n);
                     end else if (win[2] == CH_P && win[3] == CH_C) begin
                        found = 1'b1;
                        hit.kind = KIND_PALETTE;
                        hit.stream_number = NUM_W'(n);
                     end
                  end
               end
            end
         end
      end
      if (found) begin
         scan_active = 1'b0;
         pending_chunks.push_back(hit);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         end_offset = '0;
         stream_limit = '0;
         for (int k = 0; k < 8; k++) win[k] = '0;
         fill = 0;
         scan_origin = '0;
         next_offset = '0;
         scan_active = 1'b0;
         for (int k = 0; k < STREAMS; k++) begin
            last_suffix[k] = '0;
            suffix_run[k] = 0;
         end
         pending_chunks.delete();
         failures = 0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_DATA_END) end_offset = csr_data;
            else stream_limit = csr_data[COUNT_W-1:0];
         end
         // pop before push: a word accepted now cannot answer in this cycle
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_chunks.size() == 0) begin
               $error("unexpected word: kind %0d, offset %0h", rsp_chan.kind,
                      rsp_chan.header_end_offset);
               failures++;
            end else begin
               want = pending_chunks.pop_front();
               if (rsp_chan.kind !== want.kind) begin
                  $error("kind: expected %0d, got %0d", want.kind, rsp_chan.kind);
                  failures++;
               end
               if (rsp_chan.stream_number !== want.stream_number) begin
                  $error("stream_number: expected %0d, got %0d", want.stream_number,
                         rsp_chan.stream_number);
                  failures++;
               end
               if (rsp_chan.chunk_size !== want.chunk_size) begin
                  $error("chunk_size: expected %0h, got %0h", want.chunk_size,
                         rsp_chan.chunk_size);
                  failures++;
               end
               if (rsp_chan.header_end_offset !== want.header_end_offset) begin
                  $error("header_end_offset: expected %0h, got %0h",
                         want.header_end_offset, rsp_chan.header_end_offset);
                  failures++;
               end
               if (rsp_chan.tag_suffix !== want.tag_suffix) begin
                  $error("tag_suffix: expected %0h, got %0h", want.tag_suffix,
                         rsp_chan.tag_suffix);
                  failures++;
               end
            end
         end
         if (req_chan.valid && req_chan.ready)
            find_header(req_chan.op, req_chan.data_byte, req_chan.start_offset);
      end
      outstanding = pending_chunks.size();
   end

endmodule

FILE: sim/tb.sv
// Testbench top for the chunk header scanner: clock, reset, register phases and byte stimulus.
module tb;
   import achr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam int         CYCLE_LIMIT = 1000000;
   localparam int         LATENCY_PAD = 8;
   localparam int         PHASES      = 8;

   logic                clock;
   logic                reset;
   logic                csr_we;
   logic                csr_index;
   logic [OFFSET_W-1:0] csr_data;
   int                  failures;
   int                  outstanding;
   int                  cycles = 0;
   int                  sent = 0;
   int                  calm_req = 0;
   int                  calm_rsp = 0;
   logic [OFFSET_W-1:0] end_offset;
   int                  stream_limit;
   logic [15:0]         favorite [16];

   achr_req_if req_chan ();
   achr_rsp_if rsp_chan ();

   avi_chunk_header_resync #(.STREAM_SLOTS(STREAM_SLOTS_DEFAULT)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   achr_scan_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .failures    (failures),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [OFFSET_W-1:0] random_offset();
      return OFFSET_W'({$urandom(), $urandom()});
   endfunction

   function automatic logic [15:0] common_suffix();
      case ($urandom_range(0, 3))
         0: return "dc";
         1: return "wb";
         2: return "db";
         default: return "tx";
      endcase
   endfunction

   task automatic send_word(input logic [1:0] op, input logic [7:0] b,
                            input logic [OFFSET_W-1:0] start);
      int gap;
      gap = (calm_req > 0) ? 0 : pick_gap();
      if (calm_req > 0) calm_req--;
      else if ($urandom_range(0, 199) == 0) calm_req = $urandom_range(20, 80);
      if (gap > 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid = 1'b1;
      req_chan.op = op;
      req_chan.data_byte = b;
      req_chan.start_offset = start;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      sent++;
   endtask

   task automatic write_reg(input logic idx, input logic [OFFSET_W-1:0] value);
      csr_we = 1'b1;
      csr_index = idx;
      csr_data = value;
      if (idx == CSR_DATA_END) end_offset = value;
      else stream_limit = int'(value[COUNT_W-1:0]);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic settle();
      req_chan.valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (LATENCY_PAD) @(negedge clock);
   endtask

   // tag bytes first, then the size little-endian
   task automatic send_tag(input logic [31:0] tag, input logic [31:0] size, input int upto);
      logic [63:0] hdr;
      hdr = {tag, size[7:0], size[15:8], size[23:16], size[31:24]};
      for (int k = 0; k < upto; k++)
         send_word(OP_BYTE, hdr[63-8*k -: 8], random_offset());
   endtask

   task automatic scan_sequence();
      logic [OFFSET_W-1:0] origin;
      logic [7:0]          d_hi;
      logic [7:0]          d_lo;
      logic [15:0]         sfx;
      logic [31:0]         tag;
      logic [31:0]         size;
      longint unsigned     hdr_end;
      longint unsigned     room;
      longint unsigned     clamp;
      int                  lead;
      int                  upto;
      int                  lim;
      int                  stream;
      int                  r;
      lead = ($urandom_range(0, 9) < 6) ? $urandom_range(0, 3) : $urandom_range(4, 14);
      r = $urandom_range(0, 99);
      if (r < 10) origin = random_offset();
      else if (r < 12) origin = '0;
      else if (r < 15) origin = '1;
      else if (r < 25) origin = (end_offset > 24) ? end_offset - $urandom_range(0, 24) : '0;
      else origin = (end_offset > 6000) ? end_offset - $urandom_range(30, 6000) : '0;

      lim = (stream_limit > 16) ? 16 : stream_limit;
      stream = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, lim + 1);
      d_hi = CH_0 + 8'(stream / 10);
      d_lo = CH_0 + 8'(stream % 10);

      r = $urandom_range(0, 99);
      if (r < 55) sfx = favorite[stream % 16];
      else if (r < 70) sfx = {CH_P, CH_C};
      else if (r < 85) sfx = common_suffix();
      else sfx = 16'($urandom());

      r = $urandom_range(0, 99);
      if (r < 60) tag = {d_hi, d_lo, sfx};
      else if (r < 72) tag = {CH_I, CH_X, d_hi, d_lo};
      else if (r < 78) tag = {CH_J, CH_U, CH_N, CH_K};
      else if (r < 85) tag = {d_hi, d_lo, CH_P, CH_C};
      else tag = $urandom();

      hdr_end = longint'(origin) + lead + 7;
      room = (longint'(end_offset) > hdr_end) ? longint'(end_offset) - hdr_end : 0;
      clamp = (room > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : room;
      r = $urandom_range(0, 99);
      if (r < 50) size = $urandom_range(0, 32'((clamp > 4095) ? 4095 : clamp));
      else if (r < 65) size = 32'(clamp);
      else if (r < 72) size = 32'(clamp + 1);
      else size = $urandom();

      send_word(OP_RESTART, 8'($urandom()), origin);
      for (int k = 0; k < lead; k++) begin
         if ($urandom_range(0, 19) == 0) send_word(OP_UNUSED, 8'($urandom()), random_offset());
         else send_word(OP_BYTE, 8'($urandom()), random_offset());
      end
      upto = ($urandom_range(0, 99) < 8) ? $urandom_range(1, 7) : 8;
      send_tag(tag, size, upto);
      if (upto == 8) begin
         repeat ($urandom_range(0, 2)) send_word(OP_BYTE, 8'($urandom()), random_offset());
         r = $urandom_range(0, 99);
         if (r < 20) send_word(OP_END, 8'($urandom()), random_offset());
         else if (r < 23) send_word(OP_UNUSED, 8'($urandom()), random_offset());
      end
   endtask

   initial begin
      int stall;
      rsp_chan.ready = 1'b0;
      stall = 0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            rsp_chan.ready = 1'b0;
            stall--;
         end else begin
            rsp_chan.ready = 1'b1;
            if (calm_rsp > 0) calm_rsp--;
            else if ($urandom_range(0, 299) == 0) calm_rsp = $urandom_range(50, 200);
            else if ($urandom_range(0, 3) == 0) stall = pick_gap();
         end
      end
   end

   initial begin
      logic [OFFSET_W-1:0] lim_end;
      int                  lim_count;
      int                  budget;
      int                  target;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.op = OP_RESTART;
      req_chan.data_byte = '0;
      req_chan.start_offset = '0;
      csr_we = 1'b0;
      csr_index = CSR_DATA_END;
      csr_data = '0;
      end_offset = '0;
      stream_limit = 0;
      for (int k = 0; k < 16; k++) favorite[k] = common_suffix();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      write_reg(CSR_DATA_END, 40'd1000);
      write_reg(CSR_STREAM_COUNT, 40'd2);
      // idle and unused words give nothing
      send_word(OP_BYTE, 8'hFF, '1);
      send_word(OP_END, 8'h00, '0);
      send_word(OP_UNUSED, 8'hFF, '1);
      // media, then index skip, then junk cut short by the end of the list
      send_word(OP_RESTART, 8'h00, 40'd100);
      send_tag({CH_0, CH_0, "dc"}, 32'd16, 8);
      send_word(OP_RESTART, 8'h00, 40'd200);
      send_tag({CH_I, CH_X, CH_0, CH_0 + 8'd1}, 32'd0, 8);
      send_word(OP_RESTART, 8'h00, 40'd995);
      send_tag({CH_J, CH_U, CH_N, CH_K}, 32'hFFFF_FFFF, 6);
      // start beyond the end
      send_word(OP_RESTART, 8'hFF, '1);
      send_word(OP_BYTE, 8'h00, '0);

      for (int p = 0; p < PHASES; p++) begin
         settle();
         budget = 260;
         case (p)
            0: begin lim_end = '1; lim_count = 16; end
            1: begin lim_end = '0; lim_count = 1; budget = 80; end
            2: begin lim_end = random_offset(); lim_count = 31; end
            3: begin lim_end = 40'd5000 + $urandom_range(0, 95000); lim_count = 2; end
            4: begin lim_end = '1; lim_count = 0; end
            5: begin lim_end = random_offset(); lim_count = 17; end
            6: begin lim_end = random_offset(); lim_count = $urandom_range(0, 31); end
            default: begin lim_end = '1; lim_count = 1; end
         endcase
         write_reg(CSR_DATA_END, lim_end);
         write_reg(CSR_STREAM_COUNT, OFFSET_W'(lim_count));
         target = sent + budget;
         while (sent < target) scan_sequence();
      end
      settle();

      if (failures == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule

FILE: sim.f
src/achr_pkg.sv
src/achr_if.sv
src/achr_stream_table.sv
src/achr_header_match.sv
src/avi_chunk_header_resync.sv
sim/achr_scan_checker.sv
sim/tb.sv
